### hdl/bilinear_image_remap_core_assert.svh
// assertion macros for the remap core checker
// no dependencies
`ifndef BILINEAR_IMAGE_REMAP_CORE_ASSERT_SVH
`define BILINEAR_IMAGE_REMAP_CORE_ASSERT_SVH
// property that must hold at every edge out of reset
`define BIR_ASSERT(label, clk, rst, prop, msg) \
label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define BIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### hdl/bir_pkg.sv
// shared types and constants for the bilinear remap core
// no dependencies
`timescale 1ns / 1ps
package bir_pkg;
   localparam int MaxWidthDef  = 512;
   localparam int MaxHeightDef = 512;
   localparam int FracBits     = 11;
   localparam int CoordW       = 22;
   localparam int DimW         = 10;
   localparam int AddrW        = 18;
   localparam int WeightShift  = 2 * FracBits;
   localparam int NumLanes     = 3;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_INTERP = 2'd2;
   localparam logic [1:0] CSR_COLOR  = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_WAIT, ST_CALC, ST_MERGE, ST_OUT
   } state_type;

   // weights and interpolation mode handed to each lane
   typedef struct packed {
      logic [FracBits:0] gx;
      logic [FracBits:0] gy;
      logic [FracBits:0] fx;
      logic [FracBits:0] fy;
      logic              interp;
   } weight_type;
endpackage

### hdl/bir_lane.sv
// one color channel of the bilinear blend or nearest tap, pipelined multiplies
// depends on bir_pkg
`timescale 1ns / 1ps
module bir_lane (
   input  logic                clock,
   input  logic                start,
   input  bir_pkg::weight_type wt,
   input  logic [7:0]          p00,
   input  logic [7:0]          p10,
   input  logic [7:0]          p01,
   input  logic [7:0]          p11,
   output logic [7:0]          result
);
   import bir_pkg::*;
   localparam int ProdW = 2 * FracBits + 2 + 8;

   logic [ProdW-1:0] t00_ff, t10_ff, t01_ff, t11_ff;
   logic [ProdW-1:0] t00_in, t10_in, t01_in, t11_in;
   logic [7:0]       near_ff;
   logic             interp_ff;
   logic [ProdW+1:0] sum;

   // first multiply: pixel by x weight, then by y weight next stage
   logic [FracBits+8:0] a00_ff, a10_ff, a01_ff, a11_ff;
   logic [FracBits:0]   gy_ff, fy_ff;
   logic                s1_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         a00_ff <= (FracBits+9)'(p00) * (FracBits+9)'(wt.gx);
         a10_ff <= (FracBits+9)'(p10) * (FracBits+9)'(wt.fx);
         a01_ff <= (FracBits+9)'(p01) * (FracBits+9)'(wt.gx);
         a11_ff <= (FracBits+9)'(p11) * (FracBits+9)'(wt.fx);
         gy_ff  <= wt.gy;
         fy_ff  <= wt.fy;
         near_ff <= p00;
         interp_ff <= wt.interp;
      end
      s1_ff <= start;
      if (s1_ff) begin
         t00_ff <= t00_in;
         t10_ff <= t10_in;
         t01_ff <= t01_in;
         t11_ff <= t11_in;
      end
   end

   always_comb begin
      t00_in = ProdW'(a00_ff) * ProdW'(gy_ff);
      t10_in = ProdW'(a10_ff) * ProdW'(gy_ff);
      t01_in = ProdW'(a01_ff) * ProdW'(fy_ff);
      t11_in = ProdW'(a11_ff) * ProdW'(fy_ff);
      sum = (ProdW+2)'(t00_ff) + (ProdW+2)'(t10_ff) + (ProdW+2)'(t01_ff)
          + (ProdW+2)'(t11_ff) + ((ProdW+2)'(1) << (WeightShift - 1));
   end

   assign result = interp_ff ? sum[WeightShift +: 8] : near_ff;
endmodule

### hdl/bir_frame_store.sv
// frame store: one write port, one registered read port
// depends on bir_pkg
`timescale 1ns / 1ps
module bir_frame_store #(
   parameter int Depth = bir_pkg::MaxWidthDef * bir_pkg::MaxHeightDef
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [23:0]              wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [23:0]              rd_data
);
   logic [23:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### hdl/bilinear_image_remap_core.sv
// top level of the bilinear / nearest image remap core
// depends on bir_pkg, bir_frame_store, bir_lane
`timescale 1ns / 1ps
// Remap core. Write transfers (operation 0) store one 24-bit pixel into the
// frame store, ready stays high for them. Map transfers (operation 1) read
// up to four neighbours through the single read port of the frame store,
// one per cycle, then three channel lanes blend them in a two stage
// multiply pipeline and a merge stage builds the result. A bilinear map
// inside the valid area issues four reads; nearest and out-of-range maps
// issue one read. After the reads come a wait state for the last read data,
// the lane calculation states and the merge state. The next transfer is
// taken the cycle after the result transfer; an output stall holds the
// block until the result is taken. One map item is in flight at a time. A
// coordinate outside the valid area returns zero with in_range low. The
// frame store has no reset; reading a pixel that was never written gives
// undefined data.
module bilinear_image_remap_core #(
   parameter int MAX_WIDTH  = bir_pkg::MaxWidthDef,
   parameter int MAX_HEIGHT = bir_pkg::MaxHeightDef,
   parameter int FRAC_BITS  = bir_pkg::FracBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [9:0]           csr_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [17:0]          req_pixel_address,
   input  logic [7:0]           req_pixel_c0,
   input  logic [7:0]           req_pixel_c1,
   input  logic [7:0]           req_pixel_c2,
   input  logic signed [21:0]   req_src_u,
   input  logic signed [21:0]   req_src_v,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_c0,
   output logic [7:0]           rsp_out_c1,
   output logic [7:0]           rsp_out_c2,
   output logic                 rsp_in_range
);
   import bir_pkg::*;
   localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
   localparam int SAddrW = $clog2(Depth);
   localparam int MaskF = (1 << FRAC_BITS) - 1;
   localparam int IntW = CoordW - FRAC_BITS + 1;

   // configuration registers
   logic [9:0] width_ff, height_ff;
   logic       interp_ff, color_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd512;
         height_ff <= 10'd512;
         interp_ff <= 1'b1;
         color_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_INTERP: interp_ff <= csr_data[0];
            CSR_COLOR:  color_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamp active size to 2..max
   logic [12:0] w_eff, h_eff;
   always_comb begin
      if (width_ff < 10'd2) w_eff = 13'd2;
      else if (32'(width_ff) > MAX_WIDTH) w_eff = 13'(MAX_WIDTH);
      else w_eff = 13'(width_ff);
      if (height_ff < 10'd2) h_eff = 13'd2;
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = 13'(MAX_HEIGHT);
      else h_eff = 13'(height_ff);
   end

   state_type state_ff, state_in;
   logic [1:0] tap_ff, tap_in;
   logic [2:0] cnt_ff, cnt_in;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // coordinate split: floor or round half away from zero
   logic signed [IntW-1:0] ui, vi;
   logic [FRAC_BITS-1:0]   fx, fy;
   always_comb begin
      fx = req_src_u[FRAC_BITS-1:0];
      fy = req_src_v[FRAC_BITS-1:0];
      if (interp_ff) begin
         ui = IntW'(req_src_u >>> FRAC_BITS);
         vi = IntW'(req_src_v >>> FRAC_BITS);
      end else begin
         // adding half then flooring equals half away from zero, except at
         // negative exact halves, where it rounds toward zero
         ui = IntW'((IntW+FRAC_BITS)'(req_src_u) + (IntW+FRAC_BITS)'(MaskF / 2 + 1)
              >>> FRAC_BITS);
         vi = IntW'((IntW+FRAC_BITS)'(req_src_v) + (IntW+FRAC_BITS)'(MaskF / 2 + 1)
              >>> FRAC_BITS);
         if (req_src_u < 0 && req_src_u[FRAC_BITS-1:0] == FRAC_BITS'(MaskF / 2 + 1))
            ui = ui - IntW'(1);
         if (req_src_v < 0 && req_src_v[FRAC_BITS-1:0] == FRAC_BITS'(MaskF / 2 + 1))
            vi = vi - IntW'(1);
      end
   end

   logic in_ok;
   assign in_ok = !ui[IntW-1] && !vi[IntW-1]
                && ((IntW+1)'(ui) < (IntW+1)'(w_eff) - (IntW+1)'(1))
                && ((IntW+1)'(vi) < (IntW+1)'(h_eff) - (IntW+1)'(1));

   // captured map item
   logic [12:0]       w_cap_ff;
   logic [FRAC_BITS-1:0] fx_ff, fy_ff;
   logic ok_ff, mi_ff, mc_ff;

   // base address multiply registered at accept, its taps only used when in range
   logic [SAddrW-1:0] base_ff;
   always_ff @(posedge clock) begin
      if (req_fire && req_operation == OP_MAP) begin
         base_ff  <= SAddrW'(32'(vi[IntW-2:0]) * 32'(w_eff) + 32'(ui[IntW-2:0]));
         w_cap_ff <= w_eff;
         fx_ff    <= fx;
         fy_ff    <= fy;
         ok_ff    <= in_ok;
         mi_ff    <= interp_ff;
         mc_ff    <= color_ff;
      end
   end

   // frame store access
   logic [SAddrW-1:0] rd_addr;
   logic [23:0] rd_data;
   logic wr_en;
   assign wr_en = req_fire && req_operation == OP_WRITE
                  && 32'(req_pixel_address) < Depth;
   always_comb begin
      unique case (tap_ff)
         2'd0: rd_addr = base_ff;
         2'd1: rd_addr = base_ff + SAddrW'(1);
         2'd2: rd_addr = base_ff + SAddrW'(w_cap_ff);
         default: rd_addr = base_ff + SAddrW'(w_cap_ff) + SAddrW'(1);
      endcase
   end

   bir_frame_store #(.Depth(Depth)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(SAddrW'(req_pixel_address)),
      .wr_data({req_pixel_c2, req_pixel_c1, req_pixel_c0}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // tap capture: data for tap n arrives in the cycle after its address
   logic [23:0] px_ff [4];
   logic [1:0]  cap_tap_ff;
   logic        cap_en_ff;
   always_ff @(posedge clock) begin
      cap_en_ff  <= (state_ff == ST_FETCH);
      cap_tap_ff <= tap_ff;
      if (cap_en_ff) px_ff[cap_tap_ff] <= rd_data;
   end

   // lanes
   weight_type wt;
   logic lane_start;
   logic [7:0] lane_res [NumLanes];
   always_comb begin
      wt.gx = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(fx_ff);
      wt.gy = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(fy_ff);
      wt.fx = (FRAC_BITS+1)'(fx_ff);
      wt.fy = (FRAC_BITS+1)'(fy_ff);
      wt.interp = mi_ff;
   end
   assign lane_start = (state_ff == ST_CALC) && (cnt_ff == 3'd0);

   for (genvar k = 0; k < NumLanes; k++) begin : g_lane
      bir_lane u_lane (
         .clock (clock),
         .start (lane_start),
         .wt    (wt),
         .p00   (px_ff[0][8*k +: 8]),
         .p10   (px_ff[1][8*k +: 8]),
         .p01   (px_ff[2][8*k +: 8]),
         .p11   (px_ff[3][8*k +: 8]),
         .result(lane_res[k])
      );
   end

   // merge stage / output register
   logic [7:0] o0_ff, o1_ff, o2_ff;
   logic       orng_ff, ovalid_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_MERGE) begin
         o0_ff   <= ok_ff ? lane_res[0] : 8'd0;
         o1_ff   <= (ok_ff && mc_ff) ? lane_res[1] : 8'd0;
         o2_ff   <= (ok_ff && mc_ff) ? lane_res[2] : 8'd0;
         orng_ff <= ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         tap_ff    <= '0;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         cnt_ff   <= cnt_in;
         if (state_ff == ST_MERGE) ovalid_ff <= 1'b1;
         else if (rsp_ready) ovalid_ff <= 1'b0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !ovalid_ff;
            if (req_fire && req_operation == OP_MAP) begin
               state_in = ST_FETCH;
               tap_in   = '0;
            end
         end
         ST_FETCH: begin
            // skip reads when outside; nearest needs only the first tap
            if (!ok_ff || !mi_ff || tap_ff == 2'd3) begin
               state_in = ST_WAIT;
            end else begin
               tap_in = tap_ff + 2'd1;
            end
         end
         ST_WAIT: begin
            state_in = ST_CALC;
            cnt_in   = '0;
         end
         ST_CALC: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd2) state_in = ST_MERGE;
         end
         ST_MERGE: state_in = ST_OUT;
         ST_OUT: begin
            if (!ovalid_ff || rsp_ready) state_in = ST_IDLE;
            if (ovalid_ff && rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid    = ovalid_ff;
   assign rsp_out_c0   = o0_ff;
   assign rsp_out_c1   = o1_ff;
   assign rsp_out_c2   = o2_ff;
   assign rsp_in_range = orng_ff;
endmodule

### hdl/bir_checker.sv
// port level checker for the remap core, bound to the top level
// depends on bilinear_image_remap_core_assert.svh
`timescale 1ns / 1ps
`include "bilinear_image_remap_core_assert.svh"
module bir_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_operation,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_c0,
   input logic [7:0] rsp_out_c1,
   input logic [7:0] rsp_out_c2,
   input logic       rsp_in_range
);
   `BIR_ASSERT(a_out_zero, clock, reset, !rsp_valid || rsp_in_range || (rsp_out_c0 == 8'd0 && rsp_out_c1 == 8'd0 && rsp_out_c2 == 8'd0), "out of range result not zero")
   `BIR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_c0), "result dropped while stalled")
   `BIR_ASSERT_NEXT(a_map_busy, clock, reset, req_valid && req_ready && req_operation, !req_ready, "map transfer did not block next")
   `BIR_ASSERT(a_no_ready_out, clock, reset, !(rsp_valid && req_ready), "input ready while result pending")
endmodule

bind bilinear_image_remap_core bir_checker u_bir_checker (.*);
